@@ src/spd_pkg.sv @@
`default_nettype none

package spd_pkg;

  typedef enum logic [2:0] {
    CLS_UNKNOWN  = 3'd0,
    CLS_MASTER   = 3'd1,
    CLS_SLAVE    = 3'd2,
    CLS_SWEEP    = 3'd3,
    CLS_SPURIOUS = 3'd4,
    CLS_BACKWARD = 3'd5,
    CLS_MISSING  = 3'd6
  } cls_t;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned TYPE_W = 4;

  localparam logic [LEN_W-1:0] LEN_LOW  = 32'd2750;
  localparam logic [LEN_W-1:0] LEN_HIGH = 32'd6750;
  localparam int unsigned      LEN_STEP = 500;
  localparam int unsigned      OFS_W    = 12;

  localparam logic signed [TIME_W-1:0] WIN_BACK    = -32'sd400000;
  localparam logic signed [TIME_W-1:0] WIN_REPEAT  = 32'sd1000;
  localparam logic signed [TIME_W-1:0] WIN_SOON    = 32'sd18500;
  localparam logic signed [TIME_W-1:0] WIN_SLAVE   = 32'sd21500;
  localparam logic signed [TIME_W-1:0] WIN_EARLY   = 32'sd70000;
  localparam logic signed [TIME_W-1:0] WIN_SWEEP   = 32'sd350000;
  localparam logic signed [TIME_W-1:0] WIN_MISSING = 32'sd415000;

  // Pulse type of a candidate length, (len - 2750) / 500, found by a row of
  // threshold compares on the offset (at most 4000 for a candidate).
  function automatic logic [TYPE_W-1:0] type_of(input logic [OFS_W-1:0] ofs);
    logic [TYPE_W-1:0] ty;
    ty = '0;
    for (int k = 1; k <= 8; k++) begin
      if (ofs >= OFS_W'(k * LEN_STEP)) begin
        ty = TYPE_W'(k);
      end
    end
    return ty;
  endfunction

endpackage

`default_nettype wire

@@ src/sync_pulse_disambiguator_unit.sv @@
// Pipeline: each request passes through the input register, then the result register.
// Throughput: one request per cycle while out_tready does not stall the result register; the
// lock state is updated as each request moves from the input register into the result register.
// Reset (rst_n low, synchronous): both pipeline stages empty, block unlocked,
// stored master time and type cleared to zero.
`default_nettype none

module sync_pulse_disambiguator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] pulse_time, [63:32] pulse_length
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata   // [2:0] pulse_class, [7:3] zero
);

  logic                             s1_valid_r;
  logic [spd_pkg::TIME_W-1:0]       s1_time_r;
  logic [spd_pkg::LEN_W-1:0]        s1_len_r;
  logic                             out_valid_r;
  spd_pkg::cls_t                    cls_r, cls_nxt;
  logic                             locked_r, locked_nxt;
  logic [spd_pkg::TIME_W-1:0]       mtime_r, mtime_nxt;
  logic [spd_pkg::TYPE_W-1:0]       mtype_r, mtype_nxt;

  logic                             advance;
  logic                             cand, strict;
  logic [spd_pkg::OFS_W-1:0]        ofs;
  logic [spd_pkg::TYPE_W-1:0]       ty;
  logic signed [spd_pkg::TIME_W-1:0] diff;
  logic [spd_pkg::TIME_W-1:0]       m3;
  logic [spd_pkg::TIME_W-1:0]       avg;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, cls_r};

  always_comb begin
    cand   = (s1_len_r >= spd_pkg::LEN_LOW) && (s1_len_r <= spd_pkg::LEN_HIGH);
    strict = (s1_len_r > spd_pkg::LEN_LOW) && (s1_len_r < spd_pkg::LEN_HIGH);
    ofs    = spd_pkg::OFS_W'(s1_len_r - spd_pkg::LEN_LOW);
    ty     = spd_pkg::type_of(ofs);
    diff   = signed'(s1_time_r - mtime_r);
    m3     = (mtime_r << 1) + mtime_r;
    avg    = (m3 >> 2) + (s1_time_r >> 2);
  end

  always_comb begin
    cls_nxt    = spd_pkg::CLS_SPURIOUS;
    locked_nxt = locked_r;
    mtime_nxt  = mtime_r;
    mtype_nxt  = mtype_r;
    if (!locked_r) begin
      if (!cand) begin
        cls_nxt = spd_pkg::CLS_UNKNOWN;
      end else begin
        cls_nxt    = spd_pkg::CLS_MASTER;
        locked_nxt = 1'b1;
        mtime_nxt  = s1_time_r;
        mtype_nxt  = ty;
      end
    end else if (diff < 0 && diff > spd_pkg::WIN_BACK) begin
      cls_nxt = spd_pkg::CLS_BACKWARD;
    end else if (diff < spd_pkg::WIN_REPEAT) begin
      // Repeat of the master, which also covers far-backward differences.
      if (strict && ty != mtype_r) begin
        cls_nxt = spd_pkg::CLS_SPURIOUS;
      end else begin
        cls_nxt   = spd_pkg::CLS_MASTER;
        mtime_nxt = avg;
      end
    end else if (diff < spd_pkg::WIN_SOON) begin
      cls_nxt = spd_pkg::CLS_SPURIOUS;
    end else if (diff < spd_pkg::WIN_SLAVE) begin
      if (cand && (mtype_r[0] == ty[0]) && !(mtype_r[2] && ty[2])) begin
        cls_nxt = spd_pkg::CLS_SLAVE;
      end
    end else if (diff < spd_pkg::WIN_EARLY) begin
      cls_nxt = spd_pkg::CLS_SPURIOUS;
    end else if (diff < spd_pkg::WIN_SWEEP) begin
      cls_nxt = spd_pkg::CLS_SWEEP;
    end else if (cand) begin
      if (mtype_r[0] != ty[0]) begin
        cls_nxt   = spd_pkg::CLS_MASTER;
        mtime_nxt = s1_time_r;
        mtype_nxt = ty;
      end else if (diff > spd_pkg::WIN_MISSING) begin
        // A master was missed: step past it and expect the other axis next.
        cls_nxt   = spd_pkg::CLS_MISSING;
        mtime_nxt = mtime_r + spd_pkg::TIME_W'(1);
        mtype_nxt = {{(spd_pkg::TYPE_W-1){1'b0}}, ~ty[0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      locked_r    <= 1'b0;
      mtime_r     <= '0;
      mtype_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        locked_r <= locked_nxt;
        mtime_r  <= mtime_nxt;
        mtype_r  <= mtype_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_time_r <= in_tdata[31:0];
      s1_len_r  <= in_tdata[63:32];
    end
    if (advance && s1_valid_r) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Pulse length classes and master-relative time windows, in ticks.
  localparam logic [31:0] SYNC_LEN_MIN  = 32'd2750;
  localparam logic [31:0] SYNC_LEN_MAX  = 32'd6750;
  localparam logic [31:0] SYNC_LEN_STEP = 32'd500;
  localparam int          D_BACK        = -400000;
  localparam int          D_REPEAT      = 1000;
  localparam int          D_SOON        = 18500;
  localparam int          D_SLAVE       = 21500;
  localparam int          D_EARLY       = 70000;
  localparam int          D_SWEEP       = 350000;
  localparam int          D_MISSING     = 415000;
  localparam int          QUIET_LIMIT   = 5000;
  localparam int          RANDOM_ITEMS  = 1700;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] pulse_time, [63:32] pulse_length
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [2:0] pulse_class, [7:3] zero

  // Tracker state as the block should hold it.
  logic        pred_locked;
  logic [31:0] pred_master_time;
  logic [3:0]  pred_master_type;

  spd_pkg::cls_t pending_classes[$];
  int          err_count   = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          quiet_cycles = 0;

  sync_pulse_disambiguator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic spd_pkg::cls_t classify_pulse(input logic [31:0] t,
                                                   input logic [31:0] len);
    logic [3:0]         ty;
    logic signed [31:0] d;
    logic [31:0]        m3;
    logic               cand;
    logic               strict;
    ty     = 4'((len - SYNC_LEN_MIN) / SYNC_LEN_STEP);
    cand   = (len >= SYNC_LEN_MIN) && (len <= SYNC_LEN_MAX);
    strict = (len > SYNC_LEN_MIN) && (len < SYNC_LEN_MAX);
    if (!pred_locked) begin
      if (!cand) return spd_pkg::CLS_UNKNOWN;
      pred_locked      = 1'b1;
      pred_master_time = t;
      pred_master_type = ty;
      return spd_pkg::CLS_MASTER;
    end
    d = $signed(t - pred_master_time);
    if (d < 0 && d > D_BACK) return spd_pkg::CLS_BACKWARD;
    if (d < D_REPEAT) begin
      if (strict && ty != pred_master_type) return spd_pkg::CLS_SPURIOUS;
      // The averaged time is 3/4 of the old one plus 1/4 of the new one, each
      // quarter truncated on its own.
      m3 = pred_master_time * 32'd3;
      pred_master_time = (m3 >> 2) + (t >> 2);
      return spd_pkg::CLS_MASTER;
    end
    if (d < D_SOON) return spd_pkg::CLS_SPURIOUS;
    if (d < D_SLAVE) begin
      if (cand && pred_master_type[0] == ty[0] && !(pred_master_type[2] && ty[2])) begin
        return spd_pkg::CLS_SLAVE;
      end
      return spd_pkg::CLS_SPURIOUS;
    end
    if (d < D_EARLY) return spd_pkg::CLS_SPURIOUS;
    if (d < D_SWEEP) return spd_pkg::CLS_SWEEP;
    if (!cand) return spd_pkg::CLS_SPURIOUS;
    if (pred_master_type[0] != ty[0]) begin
      pred_master_time = t;
      pred_master_type = ty;
      return spd_pkg::CLS_MASTER;
    end
    if (d > D_MISSING) begin
      pred_master_time = pred_master_time + 32'd1;
      pred_master_type = {3'b000, ~ty[0]};
      return spd_pkg::CLS_MISSING;
    end
    return spd_pkg::CLS_SPURIOUS;
  endfunction

  // Entered and left at a falling edge; in_tvalid stays high on return so that
  // back-to-back requests need no gap.
  task automatic send_pulse(input logic [31:0] t, input logic [31:0] len);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {len, t};
    do @(posedge clk); while (!in_tready);
    pending_classes.push_back(classify_pulse(t, len));
    @(negedge clk);
  endtask

  task automatic send_offset(input logic [31:0] ofs, input logic [31:0] len);
    send_pulse(pred_master_time + ofs, len);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    spd_pkg::cls_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_classes.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request pending", out_tdata[2:0]));
      end else begin
        want = pending_classes.pop_front();
        if (out_tdata[2:0] != want) begin
          report_mismatch($sformatf("pulse_class got %0d expected %0d (%s)",
                                    out_tdata[2:0], want, want.name()));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (!in_tvalid && pending_classes.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_length();
    logic [31:0] edges[12];
    int          r;
    edges = '{32'd0, 32'd2749, 32'd2750, 32'd2751, 32'd3249, 32'd3250,
              32'd6249, 32'd6250, 32'd6749, 32'd6750, 32'd6751, 32'hFFFF_FFFF};
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(SYNC_LEN_MIN, SYNC_LEN_MAX);
    if (r < 70) return edges[$urandom_range(0, 11)];
    if (r < 85) return $urandom_range(0, 10000);
    return $urandom();
  endfunction

  // Offset from the current master time, drawn from one of the windows and
  // leaning towards the window bounds.
  function automatic logic [31:0] pick_offset();
    int          lo;
    int          hi;
    logic [31:0] span;
    case ($urandom_range(0, 8))
      0: begin lo = D_BACK + 1; hi = -1; end
      1: begin
        hi = D_BACK;
        lo = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : D_BACK - 80000;
      end
      2: begin lo = 0; hi = D_REPEAT - 1; end
      3: begin lo = D_REPEAT; hi = D_SOON - 1; end
      4: begin lo = D_SOON; hi = D_SLAVE - 1; end
      5: begin lo = D_SLAVE; hi = D_EARLY - 1; end
      6: begin lo = D_EARLY; hi = D_SWEEP - 1; end
      7: begin lo = D_SWEEP; hi = D_MISSING; end
      default: begin
        lo = D_MISSING + 1;
        hi = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : D_MISSING + 80000;
      end
    endcase
    span = hi - lo;
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return lo + $urandom_range(0, span);
    endcase
  endfunction

  task automatic test_unlocked_lengths();
    send_pulse(32'h0000_0000, 32'h0000_0000);
    send_pulse(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pulse($urandom(), 32'd2749);
    // The longest sync candidate locks with type 8.
    send_pulse(32'd1000, 32'd6750);
    wait_drained();
  endtask

  task automatic test_windows();
    send_offset(-1, 32'd3000);
    send_offset(D_BACK, 32'd0);
    send_offset(0, 32'd3000);
    send_offset(D_REPEAT - 1, 32'd6750);
    send_offset(D_REPEAT, 32'd2750);
    send_offset(D_SOON - 1, 32'd6751);
    send_offset(D_SOON, 32'd2000);
    send_offset(D_SOON, 32'd2750);
    send_offset(D_SLAVE - 1, 32'd4750);
    send_offset(20000, 32'd3250);
    send_offset(D_SLAVE, 32'd2750);
    send_offset(D_EARLY - 1, 32'd2750);
    send_offset(D_EARLY, 32'd0);
    send_offset(D_SWEEP - 1, 32'hFFFF_FFFF);
    send_offset(D_SWEEP, 32'd0);
    // Axis change in the late window takes over as master with type 5.
    send_offset(D_SWEEP, 32'd5250);
    // Both skip bits set: not a slave.
    send_offset(20000, 32'd5250);
    send_offset(20000, 32'd3250);
    send_offset(D_MISSING, 32'd3250);
    send_offset(D_MISSING + 1, 32'd3250);
    send_offset(D_BACK + 1, 32'd2750);
    send_offset(32'h7FFF_FFFF, 32'd2750);
    wait_drained();
  endtask

  task automatic test_random_tracking(input int n_items, input int tx_pct, input int rx_pct);
    logic [31:0] t;
    logic [31:0] len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      len = pick_length();
      if (!pred_locked || $urandom_range(0, 99) < 12) begin
        t = $urandom();
      end else begin
        t = pred_master_time + pick_offset();
      end
      send_pulse(t, len);
    end
    wait_drained();
  endtask

  initial begin
    pred_locked      = 1'b0;
    pred_master_time = '0;
    pred_master_type = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    tx_idle_pct = 38;
    rx_idle_pct = 56;
    test_unlocked_lengths();
    test_windows();
    test_random_tracking(RANDOM_ITEMS / 3, 38, 56);
    test_random_tracking(RANDOM_ITEMS / 3, 56, 38);
    test_random_tracking(RANDOM_ITEMS / 3, 0, 0);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/spd_pkg.sv
src/sync_pulse_disambiguator_unit.sv
tb/testbench.sv
